/* rtl/core/fan_level_range_table_assert.svh */
// ---------------------------------------------------------------------------
// Fan level range table assertion macros
// Shared property forms for the concurrent checks of the fan table core.
// ---------------------------------------------------------------------------
`ifndef FAN_LEVEL_RANGE_TABLE_ASSERT_SVH
`define FAN_LEVEL_RANGE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FLRT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fan table check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define FLRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fan table check failed in the following cycle");

`endif

/* rtl/core/flrt_pkg.sv */
// ---------------------------------------------------------------------------
// Fan level range table package
// Types and constants shared by the range cells and the top level.
// ---------------------------------------------------------------------------
package flrt_pkg;

    localparam int IDX_W  = 3;
    localparam int CMD_W  = 4;
    localparam int TEMP_W = 8;
    localparam int CNT_W  = 4;

    localparam logic [CMD_W-1:0] CMD_AUTO = 4'd8;
    localparam logic [CMD_W-1:0] CMD_LAST = 4'd10;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_WRITE  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    // Search token that travels down the row of cells.
    typedef struct packed {
        logic                     vld;
        logic signed [TEMP_W-1:0] temp;
        logic                     found;
        logic [IDX_W-1:0]         hit_idx;
        logic [CMD_W-1:0]         hit_cmd;
        logic                     keep;
        logic [CMD_W-1:0]         cur_cmd;
    } tok_t;

    // Entry write broadcast to every cell.
    typedef struct packed {
        logic                     en;
        logic [IDX_W-1:0]         idx;
        logic signed [TEMP_W-1:0] min;
        logic signed [TEMP_W-1:0] max;
        logic [CMD_W-1:0]         cmd;
    } wr_t;

endpackage

/* rtl/core/flrt_cell.sv */
// ---------------------------------------------------------------------------
// Fan level range table cell
// Holds one table entry and passes the search token on to its neighbour.
// ---------------------------------------------------------------------------
module flrt_cell
    import flrt_pkg::*;
#(
    parameter int CELL_INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  wr_t              wr,
    input  logic [CNT_W-1:0] count_eff,
    input  logic [IDX_W-1:0] cur_eff,
    input  tok_t             tok_in,
    output tok_t             tok_out
);

    logic signed [TEMP_W-1:0] low_reg;
    logic signed [TEMP_W-1:0] high_reg;
    logic [CMD_W-1:0]         cmd_reg;
    tok_t                     tok_reg;
    tok_t                     tok_next;
    logic                     active;
    logic                     in_range;
    logic                     hit;
    logic                     is_cur;

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.idx == IDX_W'(CELL_INDEX)))
        begin
            low_reg  <= wr.min;
            high_reg <= wr.max;
            cmd_reg  <= wr.cmd;
        end
    end

    always_comb
    begin
        active   = CNT_W'(CELL_INDEX) < count_eff;
        in_range = ($signed(tok_in.temp) >= low_reg) && ($signed(tok_in.temp) <= high_reg);
        hit      = active && in_range;
        is_cur   = cur_eff == IDX_W'(CELL_INDEX);
        tok_next = tok_in;
        if (hit && !tok_in.found)
        begin
            tok_next.found   = 1'b1;
            tok_next.hit_idx = IDX_W'(CELL_INDEX);
            tok_next.hit_cmd = cmd_reg;
        end
        if (is_cur)
        begin
            tok_next.keep    = hit;
            tok_next.cur_cmd = cmd_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* rtl/core/fan_level_range_table.sv */
// ---------------------------------------------------------------------------
// Fan level range table
// Maps a temperature sample to a fan command through a small table of
// overlapping ranges, keeping the entry in force while it still applies.
// ---------------------------------------------------------------------------
// A sample request passes through the input token register and the registers of
// the min(MAX_ENTRIES, 8) cells; the result is then registered at the output,
// or kept in the hold registers while an earlier result waits for out_ready.
// No new request is accepted until the result is in the output register; an entry write gives no result.
// Reset clears the handshake state, the entry count and the current entry;
// the table entries are undefined until written.
// ---------------------------------------------------------------------------
`include "fan_level_range_table_assert.svh"

module fan_level_range_table
    import flrt_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CNT_W-1:0]         entry_count,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     req_type,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [IDX_W-1:0]         entry_index,
    input  logic signed [TEMP_W-1:0] entry_min,
    input  logic signed [TEMP_W-1:0] entry_max,
    input  logic [CMD_W-1:0]         entry_command,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CMD_W-1:0]         fan_command,
    output logic [IDX_W-1:0]         selected_entry
);

    localparam int NCELL = (MAX_ENTRIES < (1 << IDX_W)) ? MAX_ENTRIES : (1 << IDX_W);

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] entry_count_reg;
    logic [IDX_W-1:0] cur_entry_reg;
    logic [IDX_W-1:0] cur_entry_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [CMD_W-1:0] fan_command_reg;
    logic [CMD_W-1:0] fan_command_next;
    logic [IDX_W-1:0] selected_entry_reg;
    logic [IDX_W-1:0] selected_entry_next;
    logic [CMD_W-1:0] hold_cmd_reg;
    logic [CMD_W-1:0] hold_cmd_next;
    logic [IDX_W-1:0] hold_idx_reg;
    logic [IDX_W-1:0] hold_idx_next;
    logic [CNT_W-1:0] count_eff;
    logic [IDX_W-1:0] cur_eff;
    logic             sample_accept;
    logic             scan_end;
    logic [IDX_W-1:0] res_idx;
    logic [CMD_W-1:0] res_cmd;
    wr_t              wr;
    tok_t             tok_chain [NCELL+1];

    assign cfg_ready = 1'b1;
    assign in_ready  = state_reg == ST_IDLE;

    assign count_eff = (entry_count_reg > CNT_W'(NCELL)) ? CNT_W'(NCELL) : entry_count_reg;
    assign cur_eff   = (CNT_W'(cur_entry_reg) >= count_eff) ? IDX_W'(0) : cur_entry_reg;

    assign sample_accept = in_valid && in_ready && (req_type == REQ_SAMPLE);

    assign wr.en  = in_valid && in_ready && (req_type == REQ_WRITE);
    assign wr.idx = entry_index;
    assign wr.min = entry_min;
    assign wr.max = entry_max;
    assign wr.cmd = entry_command;

    always_comb
    begin
        tok_next         = '0;
        tok_next.vld     = sample_accept;
        tok_next.temp    = temperature;
    end

    assign tok_chain[0] = tok_reg;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        flrt_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .wr        (wr),
            .count_eff (count_eff),
            .cur_eff   (cur_eff),
            .tok_in    (tok_chain[i]),
            .tok_out   (tok_chain[i+1])
        );
    end

    assign scan_end = tok_chain[NCELL].vld;

    always_comb
    begin
        if (count_eff == '0)
        begin
            res_idx = '0;
            res_cmd = CMD_AUTO;
        end
        else if (tok_chain[NCELL].keep || !tok_chain[NCELL].found)
        begin
            res_idx = cur_eff;
            res_cmd = tok_chain[NCELL].cur_cmd;
        end
        else
        begin
            res_idx = tok_chain[NCELL].hit_idx;
            res_cmd = tok_chain[NCELL].hit_cmd;
        end
        if (res_cmd > CMD_LAST)
        begin
            res_cmd = CMD_AUTO;
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        cur_entry_next      = cur_entry_reg;
        out_valid_next      = out_valid_reg && !out_ready;
        fan_command_next    = fan_command_reg;
        selected_entry_next = selected_entry_reg;
        hold_cmd_next       = hold_cmd_reg;
        hold_idx_next       = hold_idx_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_end)
                begin
                    cur_entry_next = res_idx;
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_next      = 1'b1;
                        fan_command_next    = res_cmd;
                        selected_entry_next = res_idx;
                        state_next          = ST_IDLE;
                    end
                    else
                    begin
                        hold_cmd_next = res_cmd;
                        hold_idx_next = res_idx;
                        state_next    = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    out_valid_next      = 1'b1;
                    fan_command_next    = hold_cmd_reg;
                    selected_entry_next = hold_idx_reg;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            entry_count_reg <= '0;
            cur_entry_reg   <= '0;
            out_valid_reg   <= 1'b0;
            tok_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_entry_reg <= cur_entry_next;
            out_valid_reg <= out_valid_next;
            tok_reg       <= tok_next;
            if (cfg_valid && cfg_ready)
            begin
                entry_count_reg <= entry_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fan_command_reg    <= fan_command_next;
        selected_entry_reg <= selected_entry_next;
        hold_cmd_reg       <= hold_cmd_next;
        hold_idx_reg       <= hold_idx_next;
    end

    assign out_valid      = out_valid_reg;
    assign fan_command    = fan_command_reg;
    assign selected_entry = selected_entry_reg;

    `FLRT_ASSERT_NEXT(a_sample_starts_scan, clk, rst_n, sample_accept, state_reg == ST_SCAN)
    `FLRT_ASSERT_SAME(a_end_only_in_scan, clk, rst_n, scan_end, state_reg == ST_SCAN)
    `FLRT_ASSERT_SAME(a_hold_has_output, clk, rst_n, state_reg == ST_HOLD, out_valid_reg)
    `FLRT_ASSERT_NEXT(a_empty_clears_cur, clk, rst_n, scan_end && (count_eff == '0), cur_entry_reg == '0)

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fan level range table testbench
// Loads table entries and temperature samples through the request channel,
// changes the entry count between phases and compares every result with
// the command and entry that a behavioural copy of the table selects.
// ---------------------------------------------------------------------------
module testbench
    import flrt_pkg::*;
();

    localparam int TABLE_DEPTH = 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_PCT    = 25;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic                     kind;
        logic signed [TEMP_W-1:0] temp;
        logic [IDX_W-1:0]         idx;
        logic signed [TEMP_W-1:0] lo;
        logic signed [TEMP_W-1:0] hi;
        logic [CMD_W-1:0]         cmd;
    } fan_req_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [IDX_W-1:0] entry;
    } fan_level_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CNT_W-1:0]         entry_count = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     req_type = REQ_SAMPLE;
    logic signed [TEMP_W-1:0] temperature = '0;
    logic [IDX_W-1:0]         entry_index = '0;
    logic signed [TEMP_W-1:0] entry_min = '0;
    logic signed [TEMP_W-1:0] entry_max = '0;
    logic [CMD_W-1:0]         entry_command = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [CMD_W-1:0]         fan_command;
    logic [IDX_W-1:0]         selected_entry;

    logic signed [TEMP_W-1:0] level_min [TABLE_DEPTH];
    logic signed [TEMP_W-1:0] level_max [TABLE_DEPTH];
    logic [CMD_W-1:0]         level_cmd [TABLE_DEPTH];
    logic [IDX_W-1:0]         active_entry = '0;
    logic [CNT_W-1:0]         table_count = '0;
    fan_level_t               pending_levels [$];

    int error_count = 0;
    int cycle_count = 0;
    bit steady = 1'b0;

    fan_level_range_table #(
        .MAX_ENTRIES(TABLE_DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .entry_count   (entry_count),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .temperature   (temperature),
        .entry_index   (entry_index),
        .entry_min     (entry_min),
        .entry_max     (entry_max),
        .entry_command (entry_command),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fan_command   (fan_command),
        .selected_entry(selected_entry)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    function automatic bit level_holds(input int idx, input logic signed [TEMP_W-1:0] t);
        return (t >= level_min[idx]) && (t <= level_max[idx]);
    endfunction

    function automatic void predict_fan_level(input fan_req_t r);
        int         lim;
        bit         found;
        fan_level_t res;
        if (r.kind == REQ_WRITE)
        begin
            level_min[r.idx] = r.lo;
            level_max[r.idx] = r.hi;
            level_cmd[r.idx] = r.cmd;
            return;
        end
        lim = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
        if (lim == 0)
        begin
            active_entry = '0;
            res.command = CMD_AUTO;
            res.entry = '0;
            pending_levels.push_back(res);
            return;
        end
        if (int'(active_entry) >= lim)
            active_entry = '0;
        if (!level_holds(int'(active_entry), r.temp))
        begin
            found = 1'b0;
            for (int i = 0; i < lim; i++)
            begin
                if (!found && level_holds(i, r.temp))
                begin
                    active_entry = IDX_W'(i);
                    found = 1'b1;
                end
            end
        end
        res.command = (level_cmd[active_entry] > CMD_LAST) ? CMD_AUTO
                                                           : level_cmd[active_entry];
        res.entry = active_entry;
        pending_levels.push_back(res);
    endfunction

    always @(posedge clk)
    begin : check_results
        fan_level_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_levels.size() == 0)
                report_mismatch("result with no sample request outstanding");
            else
            begin
                want = pending_levels.pop_front();
                if (fan_command !== want.command)
                    report_mismatch($sformatf("fan_command %0d, expected %0d",
                                              fan_command, want.command));
                if (selected_entry !== want.entry)
                    report_mismatch($sformatf("selected_entry %0d, expected %0d",
                                              selected_entry, want.entry));
            end
        end
    end

    function automatic fan_req_t sample_req(input logic signed [TEMP_W-1:0] t);
        fan_req_t r;
        r = '0;
        r.kind = REQ_SAMPLE;
        r.temp = t;
        r.idx = IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
        r.lo = TEMP_W'($urandom_range(0, 255));
        r.hi = TEMP_W'($urandom_range(0, 255));
        r.cmd = CMD_W'($urandom_range(0, 15));
        return r;
    endfunction

    function automatic fan_req_t entry_req(input int idx, input int lo, input int hi,
                                           input int cmd);
        fan_req_t r;
        r.kind = REQ_WRITE;
        r.temp = TEMP_W'($urandom_range(0, 255));
        r.idx = IDX_W'(idx);
        r.lo = TEMP_W'(lo);
        r.hi = TEMP_W'(hi);
        r.cmd = CMD_W'(cmd);
        return r;
    endfunction

    task automatic send_request(input fan_req_t r);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= r.kind;
        temperature <= r.temp;
        entry_index <= r.idx;
        entry_min <= r.lo;
        entry_max <= r.hi;
        entry_command <= r.cmd;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_fan_level(r);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_levels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_entry_count(input int value);
        settle();
        cfg_valid <= 1'b1;
        entry_count <= CNT_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        table_count = CNT_W'(value);
    endtask

    task automatic test_empty_table();
        send_request(sample_req(-128));
        send_request(sample_req(127));
    endtask

    // Entry four has an empty range, entry five an unknown command, and the
    // overlaps between neighbouring entries give the hysteresis.
    task automatic test_range_selection();
        send_request(entry_req(0, -128, -20, 0));
        send_request(entry_req(1, -30, 10, 3));
        send_request(entry_req(2, 0, 40, 5));
        send_request(entry_req(3, 30, 55, 10));
        send_request(entry_req(4, 50, 40, 7));
        send_request(entry_req(5, 60, 90, 12));
        send_request(entry_req(6, 100, 127, 9));
        send_request(entry_req(7, -128, 127, 4));
        write_entry_count(8);
        send_request(sample_req(-128));
        send_request(sample_req(-25));
        send_request(sample_req(5));
        send_request(sample_req(35));
        send_request(sample_req(38));
        send_request(sample_req(45));
        send_request(sample_req(70));
        send_request(sample_req(127));
        send_request(sample_req(45));
    endtask

    task automatic test_count_changes();
        write_entry_count(15);
        send_request(sample_req(127));
        write_entry_count(3);
        send_request(sample_req(5));
        send_request(sample_req(100));
        write_entry_count(9);
        send_request(sample_req(127));
        write_entry_count(0);
        send_request(sample_req(0));
    endtask

    function automatic fan_req_t random_entry();
        int lo;
        int hi;
        int mode;
        int cmd;
        lo = int'($urandom_range(0, 255)) - 128;
        mode = $urandom_range(0, 99);
        if (mode < 70)
        begin
            hi = lo + int'($urandom_range(0, 40));
            if (hi > 127)
                hi = 127;
        end
        else if (mode < 85)
        begin
            hi = lo - int'($urandom_range(1, 20));
            if (hi < -128)
                hi = -128;
        end
        else
            hi = int'($urandom_range(0, 255)) - 128;
        cmd = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 10) : $urandom_range(11, 15);
        return entry_req($urandom_range(0, TABLE_DEPTH - 1), lo, hi, cmd);
    endfunction

    function automatic logic signed [TEMP_W-1:0] temp_near_entry();
        int lim;
        int j;
        int lo;
        int hi;
        lim = (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
        if (lim == 0)
            lim = TABLE_DEPTH;
        j = $urandom_range(0, lim - 1);
        lo = int'(level_min[j]);
        hi = int'(level_max[j]);
        if (lo > hi)
            return TEMP_W'($urandom_range(0, 255));
        return TEMP_W'(lo + int'($urandom_range(0, hi - lo)));
    endfunction

    task automatic test_random_traffic();
        int counts [10] = '{8, 15, 1, 0, 8, 9, 5, 2, 7, 3};
        int roll;
        for (int p = 0; p < 10; p++)
        begin
            write_entry_count(counts[p]);
            steady = (p == 4);
            repeat (45)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 20)
                    send_request(random_entry());
                else if (roll < 88)
                    send_request(sample_req(temp_near_entry()));
                else
                    send_request(sample_req(TEMP_W'($urandom_range(0, 255))));
            end
            steady = 1'b0;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_table();
        test_range_selection();
        test_count_changes();
        test_random_traffic();
        settle();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
